@@ sv/m3i_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, term table and width and depth helpers for the 3x3 inverse block.
package m3i_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_ELEM  = 9;
  localparam int NUM_TERMS = 6;
  // Terms below this index add to the determinant, the rest subtract
  localparam int NUM_POS   = 3;

  localparam int                   THR_WIDTH = 33;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 33'd4295;
  // Fraction bits of the threshold register (unsigned Q1.32)
  localparam int                   THR_FRAC  = 32;

  // Pipeline depth of the determinant unit and of the cofactor front end
  localparam int DET_LAT = 7;
  localparam int COF_LAT = 3;

  // Element indices of the three factors of each Sarrus term
  localparam int SARRUS [NUM_TERMS][3] = '{
    '{0, 4, 8}, '{1, 5, 6}, '{2, 3, 7},
    '{0, 5, 7}, '{3, 1, 8}, '{2, 6, 4}
  };

  // Width of the signed determinant
  function automatic int det_width(input int ew);
    return 3 * ew + 3;
  endfunction

  // Stages of a lane after the determinant arrives: operand set-up,
  // range check, one quotient bit per stage, clip and sign
  function automatic int lane_lat(input int ew);
    return (ew + 1) + 3;
  endfunction

endpackage

@@ sv/m3i_det.sv @@
`timescale 1ns / 1ps
// Pipelined determinant by the rule of Sarrus, with magnitude and singular test.
module m3i_det #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic signed [ELEM_WIDTH-1:0]                 elem_i [m3i_pkg::NUM_ELEM],
  input  logic [m3i_pkg::THR_WIDTH-1:0]                thr_i,
  output logic [m3i_pkg::det_width(ELEM_WIDTH)-1:0]    det_mag_o,
  output logic                                         det_neg_o,
  output logic                                         singular_o
);
  import m3i_pkg::*;

  localparam int PW  = 2 * ELEM_WIDTH;
  localparam int LW  = 2 * ELEM_WIDTH + 1;
  localparam int TW  = 3 * ELEM_WIDTH;
  localparam int S4W = TW + 1;
  localparam int DW  = det_width(ELEM_WIDTH);
  localparam int SA  = DW + THR_FRAC;
  localparam int SB  = THR_WIDTH + 3 * FRAC_BITS;
  localparam int SCW = ((SA > SB) ? SA : SB) + 1;

  logic signed [PW-1:0]         p1_r  [NUM_TERMS];
  logic signed [ELEM_WIDTH-1:0] c1_r  [NUM_TERMS];
  logic signed [LW-1:0]         lo_r  [NUM_TERMS];
  logic signed [PW-1:0]         hi_r  [NUM_TERMS];
  logic signed [TW-1:0]         t_nxt [NUM_TERMS];
  logic signed [TW-1:0]         t_r   [NUM_TERMS];
  logic signed [S4W-1:0]        s_r   [NUM_POS];
  logic signed [DW-1:0]         det_r;
  logic [DW-1:0]                mag_r;
  logic                         neg_r;

  // First pair product of each term; hold the third factor
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      p1_r[k] <= elem_i[SARRUS[k][0]] * elem_i[SARRUS[k][1]];
      c1_r[k] <= elem_i[SARRUS[k][2]];
    end
  end

  // Third factor as two partial products on the halves of the pair product
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      lo_r[k] <= $signed({1'b0, p1_r[k][ELEM_WIDTH-1:0]}) * c1_r[k];
      hi_r[k] <= $signed(p1_r[k][PW-1:ELEM_WIDTH]) * c1_r[k];
    end
  end

  // Join partial products and apply the term sign
  always_comb begin
    logic signed [TW-1:0] sum;
    sum = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      sum      = (TW'(hi_r[k]) <<< ELEM_WIDTH) + TW'(lo_r[k]);
      t_nxt[k] = (k >= NUM_POS) ? -sum : sum;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  // Add terms in pairs, then the three pair sums
  always_ff @(posedge clk) begin
    for (int m = 0; m < NUM_POS; m++) begin
      s_r[m] <= S4W'(t_r[2*m]) + S4W'(t_r[2*m+1]);
    end
    det_r <= DW'(s_r[0]) + DW'(s_r[1]) + DW'(s_r[2]);
  end

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    neg_r <= det_r[DW-1];
    mag_r <= det_r[DW-1] ? $unsigned(-det_r) : $unsigned(det_r);
  end

  // Compare against the threshold with both sides scaled to a common point
  always_ff @(posedge clk) begin
    singular_o <= (SCW'(mag_r) << THR_FRAC) <= (SCW'(thr_i) << (3 * FRAC_BITS));
    det_mag_o  <= mag_r;
    det_neg_o  <= neg_r;
  end

endmodule

@@ sv/m3i_lane.sv @@
`timescale 1ns / 1ps
// One output lane: cofactor, then a pipelined rounding divide by the determinant.
module m3i_lane #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
  parameter int OUT_ROW    = 0,
  parameter int OUT_COL    = 0
) (
  input  logic                                      clk,
  input  logic signed [ELEM_WIDTH-1:0]              elem_i [m3i_pkg::NUM_ELEM],
  input  logic [m3i_pkg::det_width(ELEM_WIDTH)-1:0] det_mag_i,
  input  logic                                      det_neg_i,
  output logic signed [ELEM_WIDTH-1:0]              res_o,
  output logic                                      sat_o
);
  import m3i_pkg::*;

  localparam int PW  = 2 * ELEM_WIDTH;
  localparam int CFW = PW + 1;
  localparam int DW  = det_width(ELEM_WIDTH);
  localparam int QW  = ELEM_WIDTH + 1;
  localparam int NA  = PW + 2 * FRAC_BITS + 1;
  localparam int NW  = ((NA > DW) ? NA : DW) + 1;
  localparam int DQ  = DW + 1 + QW;
  localparam int CW  = (NW > DQ) ? NW : DQ;
  localparam int DLY = DET_LAT - COF_LAT;

  // Minor of element (OUT_COL, OUT_ROW): drop that row and column
  localparam int R0  = (OUT_COL == 0) ? 1 : 0;
  localparam int R1  = (OUT_COL == 2) ? 1 : 2;
  localparam int C0  = (OUT_ROW == 0) ? 1 : 0;
  localparam int C1  = (OUT_ROW == 2) ? 1 : 2;
  localparam bit ODD = ((OUT_ROW + OUT_COL) % 2) != 0;

  logic signed [PW-1:0]  p1_r;
  logic signed [PW-1:0]  p2_r;
  logic signed [CFW-1:0] cof_r;
  logic signed [CFW-1:0] cabs;
  logic [PW-1:0]         cmag_r [DLY+1];
  logic                  cneg_r [DLY+1];

  logic [CW-1:0]         rem_r  [QW+1];
  logic [CW-1:0]         den_r  [QW+1];
  logic [QW-1:0]         q_r    [QW+1];
  logic                  neg_r  [QW+1];
  logic                  ovf_r  [QW+1];
  logic [CW-1:0]         num_r;
  logic [CW-1:0]         dd_r;
  logic                  qn_r;

  logic [QW-1:0]         lim;
  logic [QW-1:0]         qv;
  logic [QW-1:0]         sv;
  logic                  clip;

  // Cross products of the minor
  always_ff @(posedge clk) begin
    p1_r <= elem_i[R0*3+C0] * elem_i[R1*3+C1];
    p2_r <= elem_i[R0*3+C1] * elem_i[R1*3+C0];
  end

  // Signed cofactor
  always_ff @(posedge clk) begin
    cof_r <= ODD ? (CFW'(p2_r) - CFW'(p1_r)) : (CFW'(p1_r) - CFW'(p2_r));
  end

  assign cabs = cof_r[CFW-1] ? -cof_r : cof_r;

  // Magnitude, then hold until the determinant is ready
  always_ff @(posedge clk) begin
    cmag_r[0] <= $unsigned(cabs[PW-1:0]);
    cneg_r[0] <= cof_r[CFW-1];
    for (int d = 1; d <= DLY; d++) begin
      cmag_r[d] <= cmag_r[d-1];
      cneg_r[d] <= cneg_r[d-1];
    end
  end

  // Numerator carries half the divisor so the floor rounds to nearest
  always_ff @(posedge clk) begin
    num_r <= (CW'(cmag_r[DLY]) << (2 * FRAC_BITS + 1)) + CW'(det_mag_i);
    dd_r  <= CW'(det_mag_i) << 1;
    qn_r  <= cneg_r[DLY] ^ det_neg_i;
  end

  // Flag quotients too large for the bit stages
  always_ff @(posedge clk) begin
    rem_r[0] <= num_r;
    den_r[0] <= dd_r;
    q_r[0]   <= '0;
    neg_r[0] <= qn_r;
    ovf_r[0] <= num_r >= (dd_r << QW);
  end

  // One restoring quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int BIT = QW - 1 - s;
    logic [CW-1:0] trial;
    logic          hit;

    assign trial = den_r[s] << BIT;
    assign hit   = rem_r[s] >= trial;

    always_ff @(posedge clk) begin
      rem_r[s+1] <= hit ? (rem_r[s] - trial) : rem_r[s];
      q_r[s+1]   <= q_r[s] | (hit ? (QW'(1) << BIT) : '0);
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  // Clip to the signed range and apply the sign
  always_comb begin
    lim  = neg_r[QW] ? (QW'(1) << (ELEM_WIDTH - 1))
                     : ((QW'(1) << (ELEM_WIDTH - 1)) - QW'(1));
    clip = ovf_r[QW] | (q_r[QW] > lim);
    qv   = clip ? lim : q_r[QW];
    sv   = neg_r[QW] ? (QW'(0) - qv) : qv;
  end

  always_ff @(posedge clk) begin
    res_o <= $signed(sv[ELEM_WIDTH-1:0]);
    sat_o <= clip;
  end

endmodule

@@ sv/matrix3x3_inverse.sv @@
`timescale 1ns / 1ps
// Top level of the 3x3 matrix inverse: input register, determinant unit, lanes and merge stage.
//
// Use: drive in_a00..in_a22 (signed Q16.16, row by row) and pulse start;
// an item is taken at every edge with start high, as busy stays low. One
// item may enter in every cycle, with no gap between items.
// Each item gives one result: out_valid is high for one cycle with the
// inverse on out_r00..out_r22, out_singular and out_saturated. There is
// no back-pressure, so the receiver must take a result when it appears.
// Each item passes through the determinant pipeline (7 stages), then
// one divider stage per quotient bit (ELEM_WIDTH + 1) in each of the
// nine lanes. Throughput is one item per cycle. A singular matrix gives
// zeros with out_singular set.
// cfg_we with cfg_wdata writes the singular threshold (unsigned Q1.32); write it
// only while no item is in flight.
// Reset (rst_n low, synchronous) drops every item in flight and restores
// the threshold to its reset value.
module matrix3x3_inverse #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ELEM_WIDTH-1:0]  in_a00,
  input  logic signed [ELEM_WIDTH-1:0]  in_a01,
  input  logic signed [ELEM_WIDTH-1:0]  in_a02,
  input  logic signed [ELEM_WIDTH-1:0]  in_a10,
  input  logic signed [ELEM_WIDTH-1:0]  in_a11,
  input  logic signed [ELEM_WIDTH-1:0]  in_a12,
  input  logic signed [ELEM_WIDTH-1:0]  in_a20,
  input  logic signed [ELEM_WIDTH-1:0]  in_a21,
  input  logic signed [ELEM_WIDTH-1:0]  in_a22,
  input  logic                          cfg_we,
  input  logic [m3i_pkg::THR_WIDTH-1:0] cfg_wdata,
  output logic                          out_valid,
  output logic signed [ELEM_WIDTH-1:0]  out_r00,
  output logic signed [ELEM_WIDTH-1:0]  out_r01,
  output logic signed [ELEM_WIDTH-1:0]  out_r02,
  output logic signed [ELEM_WIDTH-1:0]  out_r10,
  output logic signed [ELEM_WIDTH-1:0]  out_r11,
  output logic signed [ELEM_WIDTH-1:0]  out_r12,
  output logic signed [ELEM_WIDTH-1:0]  out_r20,
  output logic signed [ELEM_WIDTH-1:0]  out_r21,
  output logic signed [ELEM_WIDTH-1:0]  out_r22,
  output logic                          out_singular,
  output logic                          out_saturated
);
  import m3i_pkg::*;

  localparam int DW      = det_width(ELEM_WIDTH);
  localparam int LLAT    = lane_lat(ELEM_WIDTH);
  localparam int OUT_AGE = DET_LAT + LLAT + 1;

  logic signed [ELEM_WIDTH-1:0] a_r   [NUM_ELEM];
  logic [THR_WIDTH-1:0]         thr_r;
  logic [OUT_AGE:0]             vld_r;
  logic                         sdly_r [LLAT];
  logic [DW-1:0]                det_mag;
  logic                         det_neg;
  logic                         det_sing;
  logic signed [ELEM_WIDTH-1:0] lres  [NUM_ELEM];
  logic                         lsat  [NUM_ELEM];
  logic signed [ELEM_WIDTH-1:0] res_nxt [NUM_ELEM];
  logic signed [ELEM_WIDTH-1:0] res_r   [NUM_ELEM];
  logic                         sat_nxt;
  logic                         sat_r;
  logic                         sing_r;
  logic                         accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r[0] <= in_a00;
      a_r[1] <= in_a01;
      a_r[2] <= in_a02;
      a_r[3] <= in_a10;
      a_r[4] <= in_a11;
      a_r[5] <= in_a12;
      a_r[6] <= in_a20;
      a_r[7] <= in_a21;
      a_r[8] <= in_a22;
    end
  end

  // Advance the valid marks alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[OUT_AGE-1:0], accept};
    end
  end

  m3i_det #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_det (
    .clk        (clk),
    .elem_i     (a_r),
    .thr_i      (thr_r),
    .det_mag_o  (det_mag),
    .det_neg_o  (det_neg),
    .singular_o (det_sing)
  );

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      m3i_lane #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .OUT_ROW    (gi),
        .OUT_COL    (gj)
      ) u_lane (
        .clk       (clk),
        .elem_i    (a_r),
        .det_mag_i (det_mag),
        .det_neg_i (det_neg),
        .res_o     (lres[gi*3+gj]),
        .sat_o     (lsat[gi*3+gj])
      );
    end
  end

  // Hold the singular flag until the lanes finish
  always_ff @(posedge clk) begin
    sdly_r[0] <= det_sing;
    for (int d = 1; d < LLAT; d++) begin
      sdly_r[d] <= sdly_r[d-1];
    end
  end

  // Merge the lanes: zero a singular item, gather the clip flags
  always_comb begin
    sat_nxt = 1'b0;
    for (int k = 0; k < NUM_ELEM; k++) begin
      res_nxt[k] = sdly_r[LLAT-1] ? '0 : lres[k];
      sat_nxt    = sat_nxt | lsat[k];
    end
    sat_nxt = sat_nxt & !sdly_r[LLAT-1];
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
    sing_r <= sdly_r[LLAT-1];
  end

  assign out_valid     = vld_r[OUT_AGE];
  assign out_r00       = res_r[0];
  assign out_r01       = res_r[1];
  assign out_r02       = res_r[2];
  assign out_r10       = res_r[3];
  assign out_r11       = res_r[4];
  assign out_r12       = res_r[5];
  assign out_r20       = res_r[6];
  assign out_r21       = res_r[7];
  assign out_r22       = res_r[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

endmodule
